// ----- rtl/psn_pkg.sv -----
// psn_pkg: shared constants, widths and beat types of the photometric stereo normal block
// no dependencies
`default_nettype none
package psn_pkg;

  localparam int NumLights = 4;
  localparam int CoefWidth = 16;
  localparam int PixWidth  = 8;
  localparam int FracBits  = 13;

  localparam int RowWidth  = 64;
  localparam int SlotWidth = 16;
  localparam int CntWidth  = 3;
  localparam int IdxWidth  = 2;

  // matrix-vector widths
  localparam int ProdW = CoefWidth + PixWidth + 1;
  localparam int NW    = ProdW + $clog2(NumLights);
  localparam int MagW  = NW - 1;
  localparam int SqW   = 2 * MagW;
  localparam int SW    = SqW + 2;

  // unit normal: floor(sqrt(mag^2 * 2^28 / s))
  localparam int OneQ14  = 16384;
  localparam int QBits   = 29;
  localparam int RemW    = SW + 1;
  localparam int RtSteps = (QBits + 1) / 2;
  localparam int RtRW    = QBits + 1;
  localparam int CompW   = 16;

  // albedo: floor(sqrt(s >> 18))
  localparam int AlbShift = 2 * (FracBits - 4);
  localparam int AlbXW    = SW - AlbShift;
  localparam int AlbSteps = (AlbXW + 1) / 2;
  localparam int AlbRW    = AlbXW + 1;
  localparam int AlbW     = 20;

  // gradients
  localparam int GradShift = 8;
  localparam int GMagW     = CompW - 1;
  localparam int GNumW     = GMagW + GradShift;
  localparam int GRemW     = GMagW + 1;
  localparam int GradLat   = GNumW;

  // latencies in register stages
  localparam int MvLat   = 4;
  localparam int UnitLat = 1 + QBits + RtSteps;
  localparam int Lat     = MvLat + UnitLat + 1 + GradLat;
  localparam int AlbDly  = Lat - MvLat - AlbSteps;

  typedef enum logic [IdxWidth-1:0] {
    CFG_ROW_X  = 2'd0,
    CFG_ROW_Y  = 2'd1,
    CFG_ROW_Z  = 2'd2,
    CFG_LIGHTS = 2'd3
  } cfg_idx_e;

  localparam logic [1:0] ChanGrey = 2'd3;

  typedef struct packed {
    logic [1:0] channel;
    logic [7:0] intensity_0;
    logic [7:0] intensity_1;
    logic [7:0] intensity_2;
    logic [7:0] intensity_3;
  } in_beat_t;

  typedef struct packed {
    logic [AlbW-1:0]         albedo;
    logic signed [CompW-1:0] normal_x;
    logic signed [CompW-1:0] normal_y;
    logic signed [CompW-1:0] normal_z;
    logic signed [CompW-1:0] p_gradient;
    logic signed [CompW-1:0] q_gradient;
    logic                    geometry_valid;
  } out_beat_t;

  typedef struct packed {
    logic [RowWidth-1:0] row_x;
    logic [RowWidth-1:0] row_y;
    logic [RowWidth-1:0] row_z;
    logic [CntWidth-1:0] lights;
  } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/psn_if.sv -----
// psn_in_if / psn_out_if: valid-ready channels carrying input and result beats
// depends on psn_pkg
`default_nettype none
interface psn_in_if;
  logic               valid;
  logic               ready;
  psn_pkg::in_beat_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface psn_out_if;
  logic               valid;
  logic               ready;
  psn_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/psn_matvec.sv -----
// psn_matvec: light pseudo-inverse times intensities, squared length, four stages
// depends on psn_pkg
`default_nettype none
module psn_matvec (
  input  wire logic                           clk_i,
  input  wire logic                           en_i,
  input  wire psn_pkg::cfg_t                  cfg_i,
  input  wire psn_pkg::in_beat_t              beat_i,
  output logic signed [psn_pkg::NW-1:0]       n_o [3],
  output logic [psn_pkg::SW-1:0]              s_o,
  output logic                                grey_o
);
  localparam int L = psn_pkg::NumLights;

  logic [psn_pkg::CntWidth-1:0]           used;
  logic [7:0]                             pix [L];
  logic [psn_pkg::RowWidth-1:0]           rows [3];
  logic signed [psn_pkg::ProdW-1:0]       prod_q [3][L];
  logic signed [psn_pkg::NW-1:0]          nsum [3];
  logic signed [psn_pkg::NW-1:0]          n2_q [3];
  logic signed [psn_pkg::NW-1:0]          n3_q [3];
  logic signed [psn_pkg::NW-1:0]          n4_q [3];
  logic signed [2*psn_pkg::NW-1:0]        full [3];
  logic [psn_pkg::SqW-1:0]                sq_q [3];
  logic [psn_pkg::SW-1:0]                 s_q;
  logic [3:0]                             grey_q;

  assign used = (cfg_i.lights > psn_pkg::CntWidth'(L)) ?
                psn_pkg::CntWidth'(L) : cfg_i.lights;
  assign rows[0] = cfg_i.row_x;
  assign rows[1] = cfg_i.row_y;
  assign rows[2] = cfg_i.row_z;

  always_comb begin
    pix[0] = beat_i.intensity_0;
    pix[1] = beat_i.intensity_1;
    pix[2] = beat_i.intensity_2;
    if (L > 3) pix[L-1] = beat_i.intensity_3;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < L; i++) begin
          if (psn_pkg::CntWidth'(i) < used) begin
            prod_q[r][i] <= $signed(rows[r][psn_pkg::SlotWidth*i +: psn_pkg::CoefWidth]) *
                            $signed({1'b0, pix[i][psn_pkg::PixWidth-1:0]});
          end else begin
            prod_q[r][i] <= '0;
          end
        end
      end
      grey_q <= {grey_q[2:0], beat_i.channel == psn_pkg::ChanGrey};
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nsum[r] = '0;
      for (int i = 0; i < L; i++) begin
        nsum[r] = nsum[r] + psn_pkg::NW'(prod_q[r][i]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      full[r] = n2_q[r] * n2_q[r];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        n2_q[r] <= nsum[r];
        sq_q[r] <= full[r][psn_pkg::SqW-1:0];
        n3_q[r] <= n2_q[r];
        n4_q[r] <= n3_q[r];
      end
      s_q <= psn_pkg::SW'(sq_q[0]) + psn_pkg::SW'(sq_q[1]) + psn_pkg::SW'(sq_q[2]);
    end
  end

  assign n_o    = n4_q;
  assign s_o    = s_q;
  assign grey_o = grey_q[3];
endmodule
`default_nettype wire

// ----- rtl/psn_unit.sv -----
// psn_unit: one unit-normal component, restoring divider then square-root pipeline
// depends on psn_pkg
`default_nettype none
module psn_unit (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic signed [psn_pkg::NW-1:0]     n_i,
  input  wire logic [psn_pkg::SW-1:0]            s_i,
  output logic signed [psn_pkg::CompW-1:0]       k_o
);
  localparam int QB  = psn_pkg::QBits;
  localparam int RW  = psn_pkg::RemW;
  localparam int RS  = psn_pkg::RtSteps;
  localparam int XRW = psn_pkg::RtRW;

  logic [psn_pkg::NW-1:0]   nabs;
  logic [psn_pkg::MagW-1:0] mag;
  logic [psn_pkg::SqW-1:0]  mag2_q;
  logic [psn_pkg::SW-1:0]   den_q;
  logic                     neg_q;

  logic [RW-1:0]            dr_q [QB];
  logic [QB-1:0]            dq_q [QB];
  logic [psn_pkg::SW-1:0]   dd_q [QB];
  logic                     dn_q [QB];

  logic [XRW-1:0]           rx_q [RS];
  logic [XRW-1:0]           rr_q [RS];
  logic                     rn_q [RS];

  assign nabs = n_i[psn_pkg::NW-1] ? -n_i : n_i;
  assign mag  = nabs[psn_pkg::MagW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag2_q <= mag * mag;
      den_q  <= s_i;
      neg_q  <= n_i[psn_pkg::NW-1];
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [RW-1:0]          prev;
    logic [QB-1:0]          qprev;
    logic [psn_pkg::SW-1:0] den;
    logic                   neg;
    logic [RW-1:0]          sh;
    logic                   ge;
    if (j == 0) begin : g_first
      assign prev  = RW'(mag2_q >> 1);
      assign qprev = '0;
      assign den   = den_q;
      assign neg   = neg_q;
      assign sh    = {prev[RW-2:0], mag2_q[0]};
    end else begin : g_rest
      assign prev  = dr_q[j-1];
      assign qprev = dq_q[j-1];
      assign den   = dd_q[j-1];
      assign neg   = dn_q[j-1];
      assign sh    = {prev[RW-2:0], 1'b0};
    end
    assign ge = sh >= RW'(den);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dr_q[j] <= ge ? sh - RW'(den) : sh;
        dq_q[j] <= {qprev[QB-2:0], ge};
        dd_q[j] <= den;
        dn_q[j] <= neg;
      end
    end
  end

  for (genvar j = 0; j < RS; j++) begin : g_rt
    localparam logic [XRW-1:0] Bit = XRW'(1) << (2 * (RS - 1 - j));
    logic [XRW-1:0] x;
    logic [XRW-1:0] r;
    logic           neg;
    logic [XRW-1:0] t;
    if (j == 0) begin : g_first
      assign x   = XRW'(dq_q[QB-1]);
      assign r   = '0;
      assign neg = dn_q[QB-1];
    end else begin : g_rest
      assign x   = rx_q[j-1];
      assign r   = rr_q[j-1];
      assign neg = rn_q[j-1];
    end
    assign t = r + Bit;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (x >= t) begin
          rx_q[j] <= x - t;
          rr_q[j] <= (r >> 1) + Bit;
        end else begin
          rx_q[j] <= x;
          rr_q[j] <= r >> 1;
        end
        rn_q[j] <= neg;
      end
    end
  end

  assign k_o = rn_q[RS-1] ? -psn_pkg::CompW'(rr_q[RS-1]) : psn_pkg::CompW'(rr_q[RS-1]);
endmodule
`default_nettype wire

// ----- rtl/psn_sqrt.sv -----
// psn_sqrt: albedo square root pipeline, one result bit per stage
// depends on psn_pkg
`default_nettype none
module psn_sqrt (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic [psn_pkg::SW-1:0]       s_i,
  output logic [psn_pkg::AlbW-1:0]          alb_o
);
  localparam int AS = psn_pkg::AlbSteps;
  localparam int RW = psn_pkg::AlbRW;

  logic [RW-1:0] x_q [AS];
  logic [RW-1:0] r_q [AS];

  for (genvar j = 0; j < AS; j++) begin : g_st
    localparam logic [RW-1:0] Bit = RW'(1) << (2 * (AS - 1 - j));
    logic [RW-1:0] x;
    logic [RW-1:0] r;
    logic [RW-1:0] t;
    if (j == 0) begin : g_first
      assign x = RW'(s_i >> psn_pkg::AlbShift);
      assign r = '0;
    end else begin : g_rest
      assign x = x_q[j-1];
      assign r = r_q[j-1];
    end
    assign t = r + Bit;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (x >= t) begin
          x_q[j] <= x - t;
          r_q[j] <= (r >> 1) + Bit;
        end else begin
          x_q[j] <= x;
          r_q[j] <= r >> 1;
        end
      end
    end
  end

  assign alb_o = (r_q[AS-1] > RW'({psn_pkg::AlbW{1'b1}})) ?
                 '1 : r_q[AS-1][psn_pkg::AlbW-1:0];
endmodule
`default_nettype wire

// ----- rtl/psn_grad.sv -----
// psn_grad: gradient num*256/den, truncating toward zero and saturating, divider pipeline
// depends on psn_pkg
`default_nettype none
module psn_grad (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic signed [psn_pkg::CompW-1:0]  num_i,
  input  wire logic signed [psn_pkg::CompW-1:0]  den_i,
  output logic signed [psn_pkg::CompW-1:0]       g_o
);
  localparam int NB = psn_pkg::GNumW;
  localparam int RW = psn_pkg::GRemW;
  localparam int MW = psn_pkg::GMagW;

  logic [psn_pkg::CompW-1:0] nabs;
  logic [psn_pkg::CompW-1:0] dabs;
  logic [RW-1:0]             r_q [NB];
  logic [NB-1:0]             n_q [NB];
  logic [NB-1:0]             q_q [NB];
  logic [MW-1:0]             d_q [NB];
  logic                      s_q [NB];
  logic [NB-1:0]             qf;

  assign nabs = num_i[psn_pkg::CompW-1] ? -num_i : num_i;
  assign dabs = den_i[psn_pkg::CompW-1] ? -den_i : den_i;

  for (genvar j = 0; j < NB; j++) begin : g_st
    logic [RW-1:0] r;
    logic [NB-1:0] n;
    logic [NB-1:0] q;
    logic [MW-1:0] d;
    logic          sg;
    logic [RW-1:0] sh;
    logic          ge;
    if (j == 0) begin : g_first
      assign r  = '0;
      assign n  = {nabs[MW-1:0], psn_pkg::GradShift'(0)};
      assign q  = '0;
      assign d  = dabs[MW-1:0];
      assign sg = num_i[psn_pkg::CompW-1] ^ den_i[psn_pkg::CompW-1];
    end else begin : g_rest
      assign r  = r_q[j-1];
      assign n  = n_q[j-1];
      assign q  = q_q[j-1];
      assign d  = d_q[j-1];
      assign sg = s_q[j-1];
    end
    assign sh = {r[RW-2:0], n[NB-1]};
    assign ge = sh >= RW'(d);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j] <= ge ? sh - RW'(d) : sh;
        n_q[j] <= {n[NB-2:0], 1'b0};
        q_q[j] <= {q[NB-2:0], ge};
        d_q[j] <= d;
        s_q[j] <= sg;
      end
    end
  end

  assign qf = q_q[NB-1];

  always_comb begin
    if (s_q[NB-1]) begin
      g_o = (qf > NB'(32768)) ? psn_pkg::CompW'(-32768) : -psn_pkg::CompW'(qf);
    end else begin
      g_o = (qf > NB'(32767)) ? psn_pkg::CompW'(32767) : psn_pkg::CompW'(qf);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/photometric_stereo_normal.sv -----
// photometric_stereo_normal: top level, config registers, pipeline control and alignment
// depends on psn_pkg, psn_if, psn_matvec, psn_unit, psn_sqrt, psn_grad
//
// One pixel beat per cycle in, one result beat per cycle out while the output is not stalled.
// Every beat passes through the 4-stage matrix multiply, the 29-step divider and 15-step
// square root of the unit normal, and the 23-step gradient divider, all fully pipelined.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated. Config must be
// written only while no beat is in flight; the block itself does not enforce this.
`default_nettype none
module photometric_stereo_normal (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [psn_pkg::IdxWidth-1:0]    cfg_idx_i,
  input  wire logic [psn_pkg::RowWidth-1:0]    cfg_data_i,
  psn_in_if.sink                               in_if,
  psn_out_if.source                            out_if
);
  localparam int L = psn_pkg::Lat;

  psn_pkg::cfg_t             cfg_q;
  logic                      en;
  logic [L-1:0]              vld_q;
  logic                      out_valid_q;
  psn_pkg::out_beat_t        out_q;

  logic signed [psn_pkg::NW-1:0]    n [3];
  logic [psn_pkg::SW-1:0]           s;
  logic                             grey;
  logic [psn_pkg::AlbW-1:0]         alb;
  logic signed [psn_pkg::CompW-1:0] k [3];
  logic signed [psn_pkg::CompW-1:0] pg;
  logic signed [psn_pkg::CompW-1:0] qg;

  logic [psn_pkg::AlbW-1:0]         alb_q [psn_pkg::AlbDly];
  logic                             gz_q [psn_pkg::UnitLat][2];
  logic signed [psn_pkg::CompW-1:0] fix_q [3];
  logic                             fgrey_q;
  logic signed [psn_pkg::CompW-1:0] od_q [psn_pkg::GradLat][3];
  logic                             og_q [psn_pkg::GradLat];
  logic signed [psn_pkg::CompW-1:0] oz_t;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_x  <= '0;
      cfg_q.row_y  <= '0;
      cfg_q.row_z  <= '0;
      cfg_q.lights <= psn_pkg::CntWidth'(psn_pkg::NumLights);
    end else if (cfg_we_i) begin
      case (psn_pkg::cfg_idx_e'(cfg_idx_i))
        psn_pkg::CFG_ROW_X:  cfg_q.row_x  <= cfg_data_i;
        psn_pkg::CFG_ROW_Y:  cfg_q.row_y  <= cfg_data_i;
        psn_pkg::CFG_ROW_Z:  cfg_q.row_z  <= cfg_data_i;
        psn_pkg::CFG_LIGHTS: cfg_q.lights <= cfg_data_i[psn_pkg::CntWidth-1:0];
        default: ;
      endcase
    end
  end

  assign en          = !out_valid_q || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[L-2:0], in_if.valid};
      out_valid_q <= vld_q[L-1];
    end
  end

  psn_matvec u_matvec (
    .clk_i (clk_i), .en_i (en), .cfg_i (cfg_q), .beat_i (in_if.data),
    .n_o (n), .s_o (s), .grey_o (grey)
  );

  psn_sqrt u_sqrt (.clk_i (clk_i), .en_i (en), .s_i (s), .alb_o (alb));

  for (genvar c = 0; c < 3; c++) begin : g_unit
    psn_unit u_unit (.clk_i (clk_i), .en_i (en), .n_i (n[c]), .s_i (s), .k_o (k[c]));
  end

  assign oz_t = gz_q[psn_pkg::UnitLat-1][1] ? '0 : k[2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      alb_q[0] <= alb;
      for (int i = 1; i < psn_pkg::AlbDly; i++) alb_q[i] <= alb_q[i-1];
      gz_q[0][0] <= grey;
      gz_q[0][1] <= (s == '0);
      for (int i = 1; i < psn_pkg::UnitLat; i++) gz_q[i] <= gz_q[i-1];
      // zero-length vector gives a zero normal, and a zero z reads as one
      fix_q[0] <= gz_q[psn_pkg::UnitLat-1][1] ? '0 : k[0];
      fix_q[1] <= gz_q[psn_pkg::UnitLat-1][1] ? '0 : k[1];
      fix_q[2] <= (oz_t == '0) ? psn_pkg::CompW'(psn_pkg::OneQ14) : oz_t;
      fgrey_q  <= gz_q[psn_pkg::UnitLat-1][0];
      od_q[0]  <= fix_q;
      og_q[0]  <= fgrey_q;
      for (int i = 1; i < psn_pkg::GradLat; i++) begin
        od_q[i] <= od_q[i-1];
        og_q[i] <= og_q[i-1];
      end
    end
  end

  psn_grad u_grad_p (.clk_i (clk_i), .en_i (en), .num_i (fix_q[0]), .den_i (fix_q[2]),
                     .g_o (pg));
  psn_grad u_grad_q (.clk_i (clk_i), .en_i (en), .num_i (fix_q[1]), .den_i (fix_q[2]),
                     .g_o (qg));

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.albedo         <= alb_q[psn_pkg::AlbDly-1];
      out_q.geometry_valid <= og_q[psn_pkg::GradLat-1];
      if (og_q[psn_pkg::GradLat-1]) begin
        out_q.normal_x   <= od_q[psn_pkg::GradLat-1][0];
        out_q.normal_y   <= od_q[psn_pkg::GradLat-1][1];
        out_q.normal_z   <= od_q[psn_pkg::GradLat-1][2];
        out_q.p_gradient <= pg;
        out_q.q_gradient <= qg;
      end else begin
        out_q.normal_x   <= '0;
        out_q.normal_y   <= '0;
        out_q.normal_z   <= '0;
        out_q.p_gradient <= '0;
        out_q.q_gradient <= '0;
      end
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  a_color_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.geometry_valid |-> out_q.normal_z == '0 && out_q.p_gradient == '0)
    else $error("color beat carries geometry");
  a_grey_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.geometry_valid |-> out_q.normal_z != '0)
    else $error("grey beat with zero normal z");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[L-1] |=> out_valid_q)
    else $error("beat lost at pipeline end");
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while stalled");
endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// tb_top: self-checking testbench for photometric_stereo_normal, predicting albedo,
// unit normal and gradients per pixel beat and comparing every result beat in order
// depends on psn_pkg, psn_if and the photometric_stereo_normal rtl
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 2000000;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we = 1'b0;
  psn_pkg::cfg_idx_e            cfg_idx = psn_pkg::CFG_ROW_X;
  logic [psn_pkg::RowWidth-1:0] cfg_data = '0;

  psn_in_if  in_if ();
  psn_out_if out_if ();

  photometric_stereo_normal uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  always #10 clk_i = ~clk_i;

  // local copy of the light matrix and light count
  logic [psn_pkg::RowWidth-1:0] light_rows [3];
  logic [psn_pkg::CntWidth-1:0] light_count;

  psn_pkg::in_beat_t  pixel_q [$];
  psn_pkg::out_beat_t normal_due_q [$];
  int        send_idle = 0;
  int        recv_stall = 0;
  int        fail_cnt = 0;
  longint    cycles = 0;

  function automatic bit [63:0] isqrt(bit [63:0] x);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // largest k in [0, 1.0] with k^2 * s <= n^2 * 2^28, sign of n
  function automatic longint unit_q14(longint n, bit [63:0] s);
    bit [127:0] lim;
    bit [127:0] prod;
    bit [63:0]  mag;
    longint     lo;
    longint     hi;
    longint     mid;
    mag = (n < 0) ? -n : n;
    lim = ({64'd0, mag} * {64'd0, mag}) << 28;
    lo = 0;
    hi = psn_pkg::OneQ14;
    while (lo < hi) begin
      mid = (lo + hi + 1) >>> 1;
      prod = 128'(mid * mid) * {64'd0, s};
      if (prod <= lim) lo = mid;
      else hi = mid - 1;
    end
    return (n < 0) ? -lo : lo;
  endfunction

  function automatic longint gradient(longint num, longint den);
    longint g;
    g = (num * 256) / den;
    if (g > 32767) g = 32767;
    if (g < -32768) g = -32768;
    return g;
  endfunction

  function automatic psn_pkg::out_beat_t normal_of(psn_pkg::in_beat_t px);
    psn_pkg::out_beat_t r;
    longint    n [3];
    longint    v;
    longint    ox;
    longint    oy;
    longint    oz;
    bit [7:0]  pix [4];
    bit [63:0] s;
    bit [63:0] alb;
    int        used;
    pix = '{px.intensity_0, px.intensity_1, px.intensity_2, px.intensity_3};
    used = (light_count > psn_pkg::NumLights) ? psn_pkg::NumLights : int'(light_count);
    n = '{0, 0, 0};
    for (int i = 0; i < used; i++) begin
      v = pix[i];
      for (int k = 0; k < 3; k++)
        n[k] += longint'($signed(light_rows[k][16*i +: 16])) * v;
    end
    s = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
    alb = isqrt(s >> psn_pkg::AlbShift);
    if (alb > 1048575) alb = 1048575;
    r = '0;
    r.albedo = alb[psn_pkg::AlbW-1:0];
    if (px.channel == psn_pkg::ChanGrey) begin
      ox = 0;
      oy = 0;
      oz = 0;
      if (s != 0) begin
        ox = unit_q14(n[0], s);
        oy = unit_q14(n[1], s);
        oz = unit_q14(n[2], s);
      end
      if (oz == 0) oz = psn_pkg::OneQ14;
      r.normal_x = ox[15:0];
      r.normal_y = oy[15:0];
      r.normal_z = oz[15:0];
      r.p_gradient = 16'(gradient(ox, oz));
      r.q_gradient = 16'(gradient(oy, oz));
      r.geometry_valid = 1'b1;
    end
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else begin
      if (in_if.valid && in_if.ready)
        normal_due_q.insert(normal_due_q.size(), normal_of(in_if.data));
      if (!in_if.valid || in_if.ready) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_if.data  <= pixel_q.pop_front();
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
      fail_cnt++;
    end
  endtask

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    psn_pkg::out_beat_t e;
    psn_pkg::out_beat_t a;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall);
      if (out_if.valid && out_if.ready) begin
        a = out_if.data;
        if (normal_due_q.size() == 0) begin
          $display("%0t unexpected beat: albedo %0d", $time, a.albedo);
          fail_cnt++;
        end else begin
          e = normal_due_q.pop_front();
          check_field("albedo", e.albedo, a.albedo);
          check_field("normal_x", e.normal_x, a.normal_x);
          check_field("normal_y", e.normal_y, a.normal_y);
          check_field("normal_z", e.normal_z, a.normal_z);
          check_field("p_gradient", e.p_gradient, a.p_gradient);
          check_field("q_gradient", e.q_gradient, a.q_gradient);
          check_field("geometry_valid", e.geometry_valid, a.geometry_valid);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(psn_pkg::cfg_idx_e idx, logic [psn_pkg::RowWidth-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx == psn_pkg::CFG_LIGHTS) light_count = val[psn_pkg::CntWidth-1:0];
    else light_rows[int'(idx)] = val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_matrix(logic [63:0] rx, logic [63:0] ry, logic [63:0] rz,
                            logic [63:0] cnt);
    write_reg(psn_pkg::CFG_ROW_X, rx);
    write_reg(psn_pkg::CFG_ROW_Y, ry);
    write_reg(psn_pkg::CFG_ROW_Z, rz);
    write_reg(psn_pkg::CFG_LIGHTS, cnt);
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pixel_q.size() != 0 || in_if.valid || normal_due_q.size() != 0);
  endtask

  task automatic add_pixel(logic [1:0] ch, logic [7:0] a, logic [7:0] b,
                           logic [7:0] c, logic [7:0] d);
    psn_pkg::in_beat_t px;
    px.channel = ch;
    px.intensity_0 = a;
    px.intensity_1 = b;
    px.intensity_2 = c;
    px.intensity_3 = d;
    pixel_q.insert(pixel_q.size(), px);
  endtask

  function automatic logic [7:0] rand_pix();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 8'd0;
    if (sel == 1) return 8'd255;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [63:0] rand_row();
    logic [63:0] r;
    int          sel;
    r = {$urandom, $urandom};
    for (int i = 0; i < 4; i++) begin
      sel = $urandom_range(7);
      if (sel == 0) r[16*i +: 16] = 16'h7fff;
      else if (sel == 1) r[16*i +: 16] = 16'h8000;
      else if (sel == 2) r[16*i +: 16] = 16'h0000;
      else if (sel < 5) r[16*i +: 16] = 16'($signed(10'($urandom)));
    end
    return r;
  endfunction

  initial begin
    int cnt;
    light_rows = '{64'd0, 64'd0, 64'd0};
    light_count = 3'd4;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset matrix: zero vector on a grey and a colour beat
    add_pixel(2'd3, 8'd255, 8'd255, 8'd255, 8'd255);
    add_pixel(2'd0, 8'd255, 8'd0, 8'd255, 8'd0);
    drain();

    // extreme coefficients, z row zero forces the normal z replacement
    set_matrix({4{16'h7fff}}, {4{16'h8000}}, 64'd0, 64'd4);
    for (int ch = 0; ch < 4; ch++) add_pixel(2'(ch), 8'd255, 8'd255, 8'd255, 8'd255);
    add_pixel(2'd3, 8'd0, 8'd0, 8'd0, 8'd0);
    add_pixel(2'd3, 8'd1, 8'd0, 8'd0, 8'd0);
    drain();
    set_matrix({4{16'h7fff}}, {4{16'h8000}}, {4{16'h8000}}, 64'd4);
    add_pixel(2'd3, 8'd255, 8'd255, 8'd255, 8'd255);
    add_pixel(2'd3, 8'd255, 8'd0, 8'd0, 8'd255);
    add_pixel(2'd1, 8'd170, 8'd85, 8'd170, 8'd85);
    drain();
    set_matrix(64'h0001_0000_e000_2000, 64'h0000_2000_0000_e000,
               64'h2000_2000_2000_2000, 64'd0);
    add_pixel(2'd3, 8'd200, 8'd10, 8'd90, 8'd255);
    drain();
    for (int l = 1; l < 8; l++) begin
      write_reg(psn_pkg::CFG_LIGHTS, 64'(l));
      add_pixel(2'd3, 8'd200, 8'd10, 8'd90, 8'd255);
      add_pixel(2'd2, 8'd1, 8'd254, 8'd128, 8'd127);
      drain();
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 75; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 75; end
        default: begin send_idle = 31; recv_stall = 31; end
      endcase
      cnt = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(3, 4);
      set_matrix(rand_row(), rand_row(), rand_row(), 64'(cnt));
      for (int i = 0; i < 170; i++) begin
        add_pixel(($urandom_range(1) == 0) ? 2'd3 : 2'($urandom_range(3)),
                  rand_pix(), rand_pix(), rand_pix(), rand_pix());
        if (ph == 3 && i == 85) drain();
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/psn_pkg.sv
rtl/psn_if.sv
rtl/psn_matvec.sv
rtl/psn_unit.sv
rtl/psn_sqrt.sv
rtl/psn_grad.sv
rtl/photometric_stereo_normal.sv
dv/tb_top.sv
